@@ rtl/radial_wave_height_sum_core_defines.svh @@
// Assertion macros shared by the radial wave height sum RTL.
`ifndef RADIAL_WAVE_HEIGHT_SUM_CORE_DEFINES_SVH
`define RADIAL_WAVE_HEIGHT_SUM_CORE_DEFINES_SVH
`define RWH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RWH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/rwh_pkg.sv @@
// Package with types, constants and square root helpers for the radial wave height sum.
package rwh_pkg;
	localparam int NUM_SOURCES = 3;
	localparam int SQRT_STEPS = 17;
	localparam int D2_W = 35;
	localparam int DIST_W = 18;
	localparam logic [14:0] QUARTER = 15'd16384;

	typedef enum logic [2:0] {
		REG_POS0 = 3'd0,
		REG_POS1 = 3'd1,
		REG_POS2 = 3'd2,
		REG_SHAPE0 = 3'd3,
		REG_SHAPE1 = 3'd4,
		REG_SHAPE2 = 3'd5,
		REG_PHASE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [D2_W-1:0] rem;
		logic [D2_W-1:0] root;
	} sqrt_st_t;

	function automatic sqrt_st_t sqrt_step(sqrt_st_t st_in, logic [D2_W-1:0] bitv);
		sqrt_st_t r;
		logic [D2_W-1:0] t;
		t = st_in.root + bitv;
		r = st_in;
		if (st_in.rem >= t) begin
			r.rem = st_in.rem - t;
			r.root = (st_in.root >> 1) + bitv;
		end else begin
			r.root = st_in.root >> 1;
		end
		return r;
	endfunction
endpackage

@@ rtl/radial_wave_height_sum_core.sv @@
// Top level of the radial wave height sum pipeline.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | pos_x, pos_z
//  out     | output    | out_valid/out_stall| height
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One vertex enters per cycle while the output is not stalled.
// The square root runs one bit per stage over 17 stages; the sine takes five.
// Reset clears configuration and all valid bits.
// A stall at the output while out_valid is high freezes the whole pipeline; nothing is lost.
`include "radial_wave_height_sum_core_defines.svh"
module radial_wave_height_sum_core
	import rwh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] height,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int LAT = 1 + 1 + SQRT_STEPS + 1 + 5 + 1 + 1;

	logic [31:0] pos_q [NUM_SOURCES];
	logic [31:0] shape_q [NUM_SOURCES];
	logic [15:0] phase_q;
	logic        en;
	logic [LAT-1:0] vld_q;

	assign en = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SOURCES; k++) begin
				pos_q[k] <= '0;
				shape_q[k] <= '0;
			end
			phase_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POS0: pos_q[0] <= cfg_data;
				REG_POS1: pos_q[1] <= cfg_data;
				REG_POS2: pos_q[2] <= cfg_data;
				REG_SHAPE0: shape_q[0] <= cfg_data;
				REG_SHAPE1: shape_q[1] <= cfg_data;
				REG_SHAPE2: shape_q[2] <= cfg_data;
				REG_PHASE: phase_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic signed [16:0] term_s [NUM_SOURCES];

	for (genvar k = 0; k < NUM_SOURCES; k++) begin : g_src
		logic signed [16:0] dx_s1, dz_s1;
		logic [D2_W-1:0]    d2_s2;
		sqrt_st_t           sq_s [SQRT_STEPS+1];
		logic [DIST_W-1:0]  dist_w;
		logic [15:0]        ang_s4;
		logic signed [15:0] sine_w;
		logic signed [31:0] prod_s5;
		logic signed [33:0] rp;

		always_ff @(posedge clk) begin
			if (en) begin
				dx_s1 <= 17'(pos_x) - 17'($signed(pos_q[k][31:16]));
				dz_s1 <= 17'(pos_z) - 17'($signed(pos_q[k][15:0]));
				d2_s2 <= D2_W'($unsigned(34'(dx_s1) * 34'(dx_s1)))
					+ D2_W'($unsigned(34'(dz_s1) * 34'(dz_s1)));
			end
		end

		assign sq_s[0] = '{rem: d2_s2, root: '0};
		for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq
			sqrt_st_t r_q;
			always_ff @(posedge clk) begin
				if (en) begin
					r_q <= sqrt_step(sq_s[i], D2_W'(1) << (2 * (SQRT_STEPS - 1 - i)));
				end
			end
			assign sq_s[i+1] = r_q;
		end

		logic [33:0] mf;
		assign dist_w = DIST_W'(sq_s[SQRT_STEPS].root);
		assign mf = 34'(dist_w) * 34'(shape_q[k][31:16]);
		always_ff @(posedge clk) begin
			if (en) begin
				ang_s4 <= 16'(mf >> 5) + phase_q;
			end
		end

		rwh_sine u_sine (.clk(clk), .en(en), .ang(ang_s4), .sine(sine_w));

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s5 <= $signed(shape_q[k][15:0]) * sine_w;
			end
		end
		assign rp = 34'(prod_s5) + 34'sd8192;
		assign term_s[k] = 17'(rp >>> 14);
	end

	logic signed [17:0] sum;
	logic signed [17:0] height_q;
	assign sum = 18'(term_s[0]) + 18'(term_s[1]) + 18'(term_s[2]);
	always_ff @(posedge clk) begin
		if (en) begin
			height_q <= sum;
		end
	end
	assign height = height_q;

	`RWH_ASSERT_IMPL(a_stall_rule, clk, arst_n, in_stall, out_valid && out_stall, "stall without blocked output")
	`RWH_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "output dropped while stalled")
	`RWH_ASSERT_IMPL(a_cfg_rdy, clk, arst_n, 1'b1, cfg_ready, "config not ready")
endmodule

@@ rtl/rwh_sine.sv @@
// Pipelined Q1.14 sine of a 16-bit turn angle, five register stages.
module rwh_sine
	import rwh_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        ang,
	output logic signed [15:0] sine
);
	logic [14:0] u_s1, u_s2, u_s3;
	logic [1:0]  q_s1, q_s2, q_s3, q_s4, q_s5;
	logic [14:0] x2_s2, x2_s3;
	logic [14:0] x3_s3;
	logic signed [31:0] s_s4;
	logic [14:0] s_s5;
	logic [29:0] p2, p3, p5;
	logic signed [33:0] sfull;
	logic signed [33:0] sclip;

	assign p2 = u_s1 * u_s1;
	assign p3 = x2_s2 * u_s2;
	assign p5 = x3_s3 * x2_s3;
	assign sfull = 34'sd25736 * $signed({19'd0, u_s3}) - 34'sd10512 * $signed({19'd0, x3_s3})
		+ 34'sd1160 * $signed({19'd0, 15'(p5 >> 14)});
	assign sclip = sfull < 0 ? 34'sd0 : (sfull >>> 14);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= ang[15:14];
			u_s1 <= ang[14] ? (QUARTER - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
			q_s2 <= q_s1;
			u_s2 <= u_s1;
			x2_s2 <= 15'(p2 >> 14);
			q_s3 <= q_s2;
			u_s3 <= u_s2;
			x2_s3 <= x2_s2;
			x3_s3 <= 15'(p3 >> 14);
			q_s4 <= q_s3;
			s_s4 <= sclip > 34'sd16384 ? 32'sd16384 : 32'(sclip);
			q_s5 <= q_s4;
			s_s5 <= 15'(s_s4);
		end
	end

	assign sine = q_s5[1] ? -$signed({1'b0, s_s5}) : $signed({1'b0, s_s5});
endmodule
